// ----- design/dbads_pkg.sv -----
// ----------------------------------------------------------------------------
// dbads_pkg
// Shared constants and lookup functions for the dB attenuation DAC serializer:
// mantissa table, segment scale factors and attenuation-to-segment split.
// ----------------------------------------------------------------------------
package dbads_pkg;

   // Input transaction layout
   localparam int TRIM_FIELDS   = 8;   // trim ports on the request side
   localparam int OUT_LANE_BITS = 8;   // width of the lane_bits result field
   localparam int ATTEN_IN_W    = 8;   // master and trim width
   localparam int POS_W         = 4;   // bit_position width

   // Conversion arithmetic
   localparam int STEPS_PER_SEGMENT = 48;
   localparam int ATTEN_W    = 9;      // master + trim, at most 510
   localparam int SEG_W      = 4;      // segment 0..10
   localparam int INDEX_W    = 6;      // index 0..47
   localparam int MANT_W     = 12;
   localparam int FACTOR_W   = 25;     // 1.0 in 24 fraction bits needs 25 bits
   localparam int FRAC_W     = 24;
   localparam int PROD_W     = MANT_W + FACTOR_W;
   localparam int RAW_CODE_W = 12;
   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (FRAC_W - 1));

   // Segment = atten / 48 = (atten >> 4) / 3, with /3 done as *11 >> 5
   // (exact for 5-bit operands).
   function automatic logic [SEG_W-1:0] seg_of(input logic [ATTEN_W-1:0] atten);
      logic [ATTEN_W-1:0] scaled;
      scaled = ATTEN_W'(atten[ATTEN_W-1:4]) * ATTEN_W'(11);
      return scaled[ATTEN_W-1:5];
   endfunction

   // Index within the segment
   function automatic logic [INDEX_W-1:0] index_of(input logic [ATTEN_W-1:0] atten,
                                                   input logic [SEG_W-1:0]   seg);
      logic [ATTEN_W-1:0] base;
      logic [ATTEN_W-1:0] diff;
      base = ATTEN_W'(seg) * ATTEN_W'(STEPS_PER_SEGMENT);
      diff = atten - base;
      return diff[INDEX_W-1:0];
   endfunction

   // Mantissa table, 0x0FFF down to 0x0822
   function automatic logic [MANT_W-1:0] mantissa(input logic [INDEX_W-1:0] idx);
      logic [MANT_W-1:0] val;
      case (idx)
         6'd0:  val = 12'h FFF;  6'd1:  val = 12'h FC4;  6'd2:  val = 12'h F8B;
         6'd3:  val = 12'h F52;  6'd4:  val = 12'h F1A;  6'd5:  val = 12'h EE3;
         6'd6:  val = 12'h EAC;  6'd7:  val = 12'h E77;  6'd8:  val = 12'h E42;
         6'd9:  val = 12'h E0E;  6'd10: val = 12'h DDA;  6'd11: val = 12'h DA7;
         6'd12: val = 12'h D76;  6'd13: val = 12'h D44;  6'd14: val = 12'h D14;
         6'd15: val = 12'h CE4;  6'd16: val = 12'h CB5;  6'd17: val = 12'h C86;
         6'd18: val = 12'h C58;  6'd19: val = 12'h C2B;  6'd20: val = 12'h BFF;
         6'd21: val = 12'h BD3;  6'd22: val = 12'h BA8;  6'd23: val = 12'h B7D;
         6'd24: val = 12'h B53;  6'd25: val = 12'h B2A;  6'd26: val = 12'h B01;
         6'd27: val = 12'h AD9;  6'd28: val = 12'h AB1;  6'd29: val = 12'h A8A;
         6'd30: val = 12'h A63;  6'd31: val = 12'h A3D;  6'd32: val = 12'h A18;
         6'd33: val = 12'h 9F3;  6'd34: val = 12'h 9CE;  6'd35: val = 12'h 9AB;
         6'd36: val = 12'h 987;  6'd37: val = 12'h 964;  6'd38: val = 12'h 942;
         6'd39: val = 12'h 920;  6'd40: val = 12'h 8FF;  6'd41: val = 12'h 8DE;
         6'd42: val = 12'h 8BD;  6'd43: val = 12'h 89D;  6'd44: val = 12'h 87E;
         6'd45: val = 12'h 85F;  6'd46: val = 12'h 840;  6'd47: val = 12'h 822;
         default: val = '0;
      endcase
      return val;
   endfunction

   // round(10^(-0.3*s) * 2^24)
   function automatic logic [FACTOR_W-1:0] seg_factor(input logic [SEG_W-1:0] seg);
      logic [FACTOR_W-1:0] val;
      case (seg)
         4'd0:    val = 25'd16777216;
         4'd1:    val = 25'd8408526;
         4'd2:    val = 25'd4214246;
         4'd3:    val = 25'd2112126;
         4'd4:    val = 25'd1058571;
         4'd5:    val = 25'd530542;
         4'd6:    val = 25'd265901;
         4'd7:    val = 25'd133266;
         4'd8:    val = 25'd66791;
         4'd9:    val = 25'd33475;
         4'd10:   val = 25'd16777;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ----- design/dbads_lane_code.sv -----
// ----------------------------------------------------------------------------
// dbads_lane_code
// One lane's dB-to-linear conversion: table lookup and scale multiply into a
// product register, rounding on the register output.
// ----------------------------------------------------------------------------
module dbads_lane_code #(
   parameter int CODE_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   load,
   input  logic [dbads_pkg::ATTEN_IN_W-1:0]       master,
   input  logic [dbads_pkg::ATTEN_IN_W-1:0]       trim,
   output logic [CODE_BITS-1:0]                   code
);

   logic [dbads_pkg::ATTEN_W-1:0]    atten;
   logic [dbads_pkg::SEG_W-1:0]      seg;
   logic [dbads_pkg::INDEX_W-1:0]    index;
   logic [dbads_pkg::PROD_W-1:0]     prod_in;
   logic [dbads_pkg::PROD_W-1:0]     prod_ff;
   logic [dbads_pkg::PROD_W-1:0]     rounded;
   logic [dbads_pkg::RAW_CODE_W-1:0] raw_code;

   // Split total attenuation into segment and index; the sum never reaches
   // the deep-attenuation limit with 8-bit fields, so no zero guard is needed.
   always_comb begin
      atten   = dbads_pkg::ATTEN_W'(master) + dbads_pkg::ATTEN_W'(trim);
      seg     = dbads_pkg::seg_of(atten);
      index   = dbads_pkg::index_of(atten, seg);
      prod_in = dbads_pkg::PROD_W'(dbads_pkg::mantissa(index))
              * dbads_pkg::PROD_W'(dbads_pkg::seg_factor(seg));
   end

   // Hold the product until the next transaction moves in
   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   // Round half up and drop the fraction
   assign rounded  = prod_ff + dbads_pkg::ROUND_HALF;
   assign raw_code = rounded[dbads_pkg::FRAC_W +: dbads_pkg::RAW_CODE_W];
   assign code     = CODE_BITS'(raw_code);

endmodule

// ----- design/dbads_serializer.sv -----
// ----------------------------------------------------------------------------
// dbads_serializer
// Shifts the lane codes out MSB first, one bit-parallel frame per cycle.
// ----------------------------------------------------------------------------
module dbads_serializer #(
   parameter int OUT_LANES = 8,
   parameter int CODE_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   load,
   input  logic                                   group,
   input  logic [CODE_BITS-1:0]                   codes [OUT_LANES],
   output logic                                   free,
   output logic                                   rsp_valid,
   output logic                                   rsp_group_load,
   output logic [dbads_pkg::OUT_LANE_BITS-1:0]    rsp_lane_bits,
   output logic [dbads_pkg::POS_W-1:0]            rsp_bit_position,
   output logic                                   rsp_last_bit
);

   localparam logic [dbads_pkg::POS_W-1:0] TOP_POS = dbads_pkg::POS_W'(CODE_BITS - 1);

   logic                          active_ff;
   logic                          active_in;
   logic [dbads_pkg::POS_W-1:0]   pos_ff;
   logic [dbads_pkg::POS_W-1:0]   pos_in;
   logic                          group_ff;
   logic [CODE_BITS-1:0]          shift_ff [OUT_LANES];

   // Free when idle or presenting the final bit of a frame
   assign free = !active_ff || (pos_ff == '0);

   // Advance the bit counter; reload or drop to idle after bit zero
   always_comb begin
      active_in = active_ff;
      pos_in    = pos_ff;
      if (load) begin
         active_in = 1'b1;
         pos_in    = TOP_POS;
      end else if (active_ff) begin
         if (pos_ff == '0) begin
            active_in = 1'b0;
         end else begin
            pos_in = pos_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         pos_ff    <= '0;
      end else begin
         active_ff <= active_in;
         pos_ff    <= pos_in;
      end
   end

   // Load or shift the per-lane code registers
   always_ff @(posedge clock) begin
      if (load) begin
         group_ff <= group;
      end
      for (int i = 0; i < OUT_LANES; i++) begin
         if (load) begin
            shift_ff[i] <= codes[i];
         end else if (active_ff) begin
            shift_ff[i] <= shift_ff[i] << 1;
         end
      end
   end

   // Present the current frame
   always_comb begin
      rsp_lane_bits = '0;
      for (int i = 0; i < OUT_LANES; i++) begin
         rsp_lane_bits[i] = shift_ff[i][CODE_BITS-1];
      end
   end

   assign rsp_valid        = active_ff;
   assign rsp_group_load   = group_ff;
   assign rsp_bit_position = pos_ff;
   assign rsp_last_bit     = active_ff && (pos_ff == '0);

endmodule

// ----- design/db_attenuation_dac_serializer.sv -----
// Path: a taken start passes through the capture registers, the lane product
// registers and the serializer; frames then follow, one frame per cycle on rsp_valid.
// Flow: the serializer emits one code bit per lane per cycle and takes the next
// transaction while it presents the final bit of the current one.
// Reset: synchronous, clears pipeline valids and the serializer; the result
// receiver cannot stall.
// ----------------------------------------------------------------------------
// db_attenuation_dac_serializer
// Converts a master attenuation plus per-lane trims (eighth-dB steps) into
// linear DAC codes and sends them MSB first as bit-parallel frames.
// ----------------------------------------------------------------------------
module db_attenuation_dac_serializer #(
   parameter int LANES     = 8,
   parameter int CODE_BITS = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_group,
   input  logic [dbads_pkg::ATTEN_IN_W-1:0]       req_master_attenuation,
   input  logic [dbads_pkg::ATTEN_IN_W-1:0]       req_trim_0,
   input  logic [dbads_pkg::ATTEN_IN_W-1:0]       req_trim_1,
   input  logic [dbads_pkg::ATTEN_IN_W-1:0]       req_trim_2,
   input  logic [dbads_pkg::ATTEN_IN_W-1:0]       req_trim_3,
   input  logic [dbads_pkg::ATTEN_IN_W-1:0]       req_trim_4,
   input  logic [dbads_pkg::ATTEN_IN_W-1:0]       req_trim_5,
   input  logic [dbads_pkg::ATTEN_IN_W-1:0]       req_trim_6,
   input  logic [dbads_pkg::ATTEN_IN_W-1:0]       req_trim_7,
   output logic                                   rsp_valid,
   output logic                                   rsp_group_load,
   output logic [dbads_pkg::OUT_LANE_BITS-1:0]    rsp_lane_bits,
   output logic [dbads_pkg::POS_W-1:0]            rsp_bit_position,
   output logic                                   rsp_last_bit
);

   // Only lanes 0..7 reach the result field, so only those are built
   localparam int OUT_LANES = (LANES < dbads_pkg::OUT_LANE_BITS) ? LANES
                                                                 : dbads_pkg::OUT_LANE_BITS;

   logic [dbads_pkg::ATTEN_IN_W-1:0] trim_port [dbads_pkg::TRIM_FIELDS];
   logic [dbads_pkg::ATTEN_IN_W-1:0] trim_ff   [OUT_LANES];
   logic [dbads_pkg::ATTEN_IN_W-1:0] master_ff;
   logic                             group_s1_ff;
   logic                             group_s2_ff;
   logic                             s1_valid_ff;
   logic                             s1_valid_in;
   logic                             s2_valid_ff;
   logic                             s2_valid_in;
   logic                             accept;
   logic                             s1_move;
   logic                             s2_move;
   logic                             ser_free;
   logic [CODE_BITS-1:0]             codes [OUT_LANES];

   assign trim_port[0] = req_trim_0;
   assign trim_port[1] = req_trim_1;
   assign trim_port[2] = req_trim_2;
   assign trim_port[3] = req_trim_3;
   assign trim_port[4] = req_trim_4;
   assign trim_port[5] = req_trim_5;
   assign trim_port[6] = req_trim_6;
   assign trim_port[7] = req_trim_7;

   // Stage handoff: each stage moves when the one after it is open
   assign s2_move     = s2_valid_ff && ser_free;
   assign s1_move     = s1_valid_ff && (!s2_valid_ff || s2_move);
   assign busy        = s1_valid_ff && !s1_move;
   assign accept      = start && !busy;
   assign s1_valid_in = accept  || (s1_valid_ff && !s1_move);
   assign s2_valid_in = s1_move || (s2_valid_ff && !s2_move);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Capture the request transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         group_s1_ff <= req_group;
         master_ff   <= req_master_attenuation;
         for (int i = 0; i < OUT_LANES; i++) begin
            trim_ff[i] <= trim_port[i];
         end
      end
      if (s1_move) begin
         group_s2_ff <= group_s1_ff;
      end
   end

   // Per-lane conversion
   for (genvar g = 0; g < OUT_LANES; g++) begin : g_lane
      dbads_lane_code #(
         .CODE_BITS (CODE_BITS)
      ) u_lane (
         .clock  (clock),
         .load   (s1_move),
         .master (master_ff),
         .trim   (trim_ff[g]),
         .code   (codes[g])
      );
   end

   dbads_serializer #(
      .OUT_LANES (OUT_LANES),
      .CODE_BITS (CODE_BITS)
   ) u_serializer (
      .clock            (clock),
      .reset            (reset),
      .load             (s2_move),
      .group            (group_s2_ff),
      .codes            (codes),
      .free             (ser_free),
      .rsp_valid        (rsp_valid),
      .rsp_group_load   (rsp_group_load),
      .rsp_lane_bits    (rsp_lane_bits),
      .rsp_bit_position (rsp_bit_position),
      .rsp_last_bit     (rsp_last_bit)
   );

endmodule
